// ===== rtl/core/tsrc_pkg.sv =====
// Shared types, constants and ones' complement helper for the TCP source port rewrite block.
`timescale 1ns / 1ps
`default_nettype none
package tsrc_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MATCH_SRC_PORT  = 2'd0;
   localparam logic [1:0] CSR_NEW_SRC_PORT    = 2'd1;
   localparam logic [1:0] CSR_BYPASS_DST_PORT = 2'd2;

   localparam logic [15:0] MATCH_SRC_PORT_RESET  = 16'd9999;
   localparam logic [15:0] NEW_SRC_PORT_RESET    = 16'd123;
   localparam logic [15:0] BYPASS_DST_PORT_RESET = 16'd22;

   // Byte positions within the IPv4 header.
   localparam logic [15:0] BYTE_IHL      = 16'd0;
   localparam logic [15:0] BYTE_TLEN_HI  = 16'd2;
   localparam logic [15:0] BYTE_TLEN_LO  = 16'd3;
   localparam logic [15:0] BYTE_PROTOCOL = 16'd9;
   localparam logic [15:0] BYTE_SRC_A_LO = 16'd13;
   localparam logic [15:0] BYTE_SRC_B_LO = 16'd15;
   localparam logic [15:0] BYTE_DST_A_LO = 16'd17;
   localparam logic [15:0] BYTE_DST_B_LO = 16'd19;

   // Offsets within the TCP segment.
   localparam logic [15:0] SEG_SRC_PORT_END = 16'd2;
   localparam logic [15:0] SEG_DST_PORT_END = 16'd4;
   localparam logic [15:0] SEG_CSUM_HI      = 16'd16;
   localparam logic [15:0] SEG_CSUM_LO      = 16'd17;

   localparam logic [7:0]  TCP_PROTO   = 8'd6;
   localparam logic [3:0]  MIN_IHL     = 4'd5;
   localparam logic [16:0] MIN_TCP_LEN = 17'd20;
   localparam logic [15:0] COUNT_MAX   = 16'hffff;

   typedef struct packed {
      logic [15:0] match_src_port;
      logic [15:0] new_src_port;
      logic [15:0] bypass_dst_port;
   } cfg_type;

   // Parser state as it stands after the final byte of a packet.
   typedef struct packed {
      logic [3:0]  header_words;
      logic [7:0]  protocol;
      logic [15:0] byte_count;
      logic [15:0] total_length;
      logic [15:0] seg_sport;
      logic [15:0] seg_dport;
      logic [15:0] seg_sum;
      logic [15:0] addr_sum;
      logic [7:0]  high_byte_hold;
   } snap_type;

   // Ones' complement add with end-around carry; never wraps a second time.
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tsrc_parse.sv =====
// Byte parser: header field capture and running segment sum, one byte per cycle while byte_valid is high.
`timescale 1ns / 1ps
`default_nettype none
module tsrc_parse (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              byte_valid,
   input  wire logic [7:0]        byte_data,
   input  wire logic              byte_last,
   output tsrc_pkg::snap_type     snap
);

   logic [15:0] count_ff, count_in;
   logic [3:0]  hw_ff, hw_in;
   logic [7:0]  proto_ff, proto_in;
   logic [15:0] tlen_ff, tlen_in;
   logic [15:0] src_ff, src_in;
   logic [15:0] dst_ff, dst_in;
   logic [15:0] seg_sum_ff, seg_sum_in;
   logic [15:0] addr_sum_ff, addr_sum_in;
   logic [7:0]  hold_ff, hold_in;
   logic [7:0]  prev_ff;
   logic [15:0] start;
   logic [15:0] off;
   logic        in_seg;

   always_comb begin
      hw_in       = hw_ff;
      tlen_in     = tlen_ff;
      proto_in    = proto_ff;
      addr_sum_in = addr_sum_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      seg_sum_in  = seg_sum_ff;
      hold_in     = hold_ff;

      case (count_ff)
         tsrc_pkg::BYTE_IHL:      hw_in = byte_data[3:0];
         tsrc_pkg::BYTE_TLEN_HI:  tlen_in = {byte_data, tlen_ff[7:0]};
         tsrc_pkg::BYTE_TLEN_LO:  tlen_in = {tlen_ff[15:8], byte_data};
         tsrc_pkg::BYTE_PROTOCOL: proto_in = byte_data;
         default: ;
      endcase

      // Address words are summed as soon as their low byte arrives.
      if (count_ff inside {tsrc_pkg::BYTE_SRC_A_LO, tsrc_pkg::BYTE_SRC_B_LO,
                           tsrc_pkg::BYTE_DST_A_LO, tsrc_pkg::BYTE_DST_B_LO}) begin
         addr_sum_in = tsrc_pkg::oc_add(addr_sum_ff, {prev_ff, byte_data});
      end

      start  = {10'd0, hw_in, 2'b00};
      off    = count_ff - start;
      in_seg = (hw_in >= tsrc_pkg::MIN_IHL) && (count_ff >= start) && (count_ff < tlen_in);

      if (in_seg) begin
         if (off < tsrc_pkg::SEG_SRC_PORT_END) begin
            src_in = {src_ff[7:0], byte_data};
         end else begin
            if (off < tsrc_pkg::SEG_DST_PORT_END) begin
               dst_in = {dst_ff[7:0], byte_data};
            end
            // The checksum field itself counts as zero.
            if (off != tsrc_pkg::SEG_CSUM_HI && off != tsrc_pkg::SEG_CSUM_LO) begin
               if (!off[0]) begin
                  hold_in = byte_data;
               end else begin
                  seg_sum_in = tsrc_pkg::oc_add(seg_sum_ff, {hold_ff, byte_data});
               end
            end
         end
      end

      count_in = (count_ff != tsrc_pkg::COUNT_MAX) ? count_ff + 16'd1 : count_ff;

      snap.header_words   = hw_in;
      snap.protocol       = proto_in;
      snap.byte_count     = count_in;
      snap.total_length   = tlen_in;
      snap.seg_sport      = src_in;
      snap.seg_dport      = dst_in;
      snap.seg_sum        = seg_sum_in;
      snap.addr_sum       = addr_sum_in;
      snap.high_byte_hold = hold_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (byte_valid && byte_last)) begin
         count_ff    <= '0;
         hw_ff       <= '0;
         proto_ff    <= '0;
         tlen_ff     <= '0;
         src_ff      <= '0;
         dst_ff      <= '0;
         seg_sum_ff  <= '0;
         addr_sum_ff <= '0;
         hold_ff     <= '0;
         prev_ff     <= '0;
      end else if (byte_valid) begin
         count_ff    <= count_in;
         hw_ff       <= hw_in;
         proto_ff    <= proto_in;
         tlen_ff     <= tlen_in;
         src_ff      <= src_in;
         dst_ff      <= dst_in;
         seg_sum_ff  <= seg_sum_in;
         addr_sum_ff <= addr_sum_in;
         hold_ff     <= hold_in;
         prev_ff     <= byte_data;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/tsrc_finish.sv =====
// End-of-packet decision and checksum completion, two stages and a result register.
`timescale 1ns / 1ps
`default_nettype none
module tsrc_finish (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tsrc_pkg::cfg_type  cfg,
   input  wire logic               snap_load,
   input  wire tsrc_pkg::snap_type snap,
   output logic                    snap_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic                    rsp_action,
   output logic [15:0]             rsp_checksum
);

   tsrc_pkg::snap_type snap_ff;
   logic        snap_valid_ff;
   logic        mid_valid_ff;
   logic        mid_ok_ff, mid_ok_in;
   logic [15:0] mid_a_ff, mid_a_in;
   logic [15:0] mid_b_ff, mid_b_in;
   logic [15:0] mid_c_ff, mid_c_in;
   logic        rsp_valid_ff;
   logic        rsp_action_ff;
   logic [15:0] rsp_checksum_ff, rsp_checksum_in;

   logic        rsp_free, mid_move, mid_free, snap_move;
   logic [15:0] seg_start;
   logic [15:0] tcp_len;
   logic [15:0] pad;
   logic [15:0] sum_ab;

   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign mid_move   = mid_valid_ff && rsp_free;
   assign mid_free   = !mid_valid_ff || mid_move;
   assign snap_move  = snap_valid_ff && mid_free;
   assign snap_ready = !snap_valid_ff || snap_move;

   always_comb begin
      seg_start = {10'd0, snap_ff.header_words, 2'b00};
      tcp_len   = snap_ff.total_length - seg_start;
      // An odd segment ends with a lone high byte padded by a zero.
      pad       = tcp_len[0] ? {snap_ff.high_byte_hold, 8'h00} : 16'h0000;
      mid_ok_in = (snap_ff.header_words >= tsrc_pkg::MIN_IHL)
               && (snap_ff.protocol == tsrc_pkg::TCP_PROTO)
               && (snap_ff.byte_count >= snap_ff.total_length)
               && ({1'b0, snap_ff.total_length} >= ({1'b0, seg_start} + tsrc_pkg::MIN_TCP_LEN))
               && (snap_ff.seg_dport != cfg.bypass_dst_port)
               && (snap_ff.seg_sport == cfg.match_src_port);
      mid_a_in  = tsrc_pkg::oc_add(snap_ff.seg_sum, snap_ff.addr_sum);
      mid_b_in  = tsrc_pkg::oc_add(pad, cfg.new_src_port);
      mid_c_in  = tcp_len + {8'd0, tsrc_pkg::TCP_PROTO};
   end

   always_comb begin
      sum_ab          = tsrc_pkg::oc_add(mid_a_ff, mid_b_ff);
      rsp_checksum_in = mid_ok_ff ? ~tsrc_pkg::oc_add(sum_ab, mid_c_ff) : 16'h0000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
         mid_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         snap_valid_ff <= snap_load || (snap_valid_ff && !snap_move);
         mid_valid_ff  <= snap_move || (mid_valid_ff && !mid_move);
         rsp_valid_ff  <= mid_move || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (snap_load) begin
         snap_ff <= snap;
      end
      if (snap_move) begin
         mid_ok_ff <= mid_ok_in;
         mid_a_ff  <= mid_a_in;
         mid_b_ff  <= mid_b_in;
         mid_c_ff  <= mid_c_in;
      end
      if (mid_move) begin
         rsp_action_ff   <= mid_ok_ff;
         rsp_checksum_ff <= rsp_checksum_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_action   = rsp_action_ff;
   assign rsp_checksum = rsp_checksum_ff;

endmodule
`default_nettype wire

// ===== rtl/core/tcp_source_port_rewrite_checksum_core.sv =====
// Top level of the TCP source port rewrite checksum block.
//
// An IPv4 packet enters on the req_ channel one byte per item, req_tlast on
// its final byte. For each packet one item leaves on the rsp_ channel:
// rsp_tuser says whether the source port is to be rewritten and rsp_tdata
// carries the new TCP checksum (zero when the packet passes unchanged).
// Registers are written through the csr_ channel, which is always ready.
// Bytes are taken one per cycle while no final byte waits; each address
// and segment byte adds into a 16-bit ones' complement sum in the parser.
// A result passes the snapshot, middle and result registers in turn.
// While the receiver stalls, non-final bytes keep flowing and up to three
// finished results wait in the completion stages; a further final byte
// waits at the input register until a stage frees up.
// Reset clears the packet state and the pipeline and loads the register
// defaults: match port 9999, new port 123, bypass port 22.
`timescale 1ns / 1ps
`default_nettype none
module tcp_source_port_rewrite_checksum_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] new_checksum
   output logic             rsp_tuser,   // [0] action
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   tsrc_pkg::cfg_type  cfg_ff;
   tsrc_pkg::snap_type snap;
   logic       in_valid_ff;
   logic [7:0] in_data_ff;
   logic       in_last_ff;
   logic       in_move;
   logic       snap_ready;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.match_src_port  <= tsrc_pkg::MATCH_SRC_PORT_RESET;
         cfg_ff.new_src_port    <= tsrc_pkg::NEW_SRC_PORT_RESET;
         cfg_ff.bypass_dst_port <= tsrc_pkg::BYPASS_DST_PORT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            tsrc_pkg::CSR_MATCH_SRC_PORT:  cfg_ff.match_src_port  <= csr_data;
            tsrc_pkg::CSR_NEW_SRC_PORT:    cfg_ff.new_src_port    <= csr_data;
            tsrc_pkg::CSR_BYPASS_DST_PORT: cfg_ff.bypass_dst_port <= csr_data;
            default: ;
         endcase
      end
   end

   // Non-final bytes never wait; a final byte needs a free completion slot.
   assign in_move    = in_valid_ff && (!in_last_ff || snap_ready);
   assign req_tready = !in_valid_ff || in_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= (req_tvalid && req_tready) || (in_valid_ff && !in_move);
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   tsrc_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (in_move),
      .byte_data  (in_data_ff),
      .byte_last  (in_last_ff),
      .snap       (snap)
   );

   tsrc_finish u_finish (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .snap_load    (in_move && in_last_ff),
      .snap         (snap),
      .snap_ready   (snap_ready),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_action   (rsp_tuser),
      .rsp_checksum (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   a_pass_has_zero_checksum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 16'h0000)
      else $error("passed packet carries a non-zero checksum");

   a_body_bytes_never_wait: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !in_last_ff |-> in_move)
      else $error("non-final byte held at the input register");

   a_no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   a_body_byte_no_result: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(in_move && in_last_ff) && !snap_ready |=> snap_ready || !rsp_tvalid)
      else $error("completion stages advanced without a result");
`endif

endmodule
`default_nettype wire
